[hdl/mpvl_pkg.sv]
`timescale 1ns / 1ps

package mpvl_pkg;

   localparam int FUNC_BITS     = 3;
   localparam int SLOT_BITS     = 8;
   localparam int PREFIX_BITS   = 24;
   localparam int VENDOR_BITS   = 4;
   localparam int SOURCE_BITS   = 3;
   localparam int ENTRY_BITS    = PREFIX_BITS + VENDOR_BITS;
   localparam int LA_SLOT_BITS  = 4;
   localparam int LA_BIT_POS    = 17;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;
   localparam int TBL_CNT_BITS   = 9;
   localparam int LA_CNT_BITS    = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DYN_TABLE_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STATIC_TABLE_COUNT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DYN_LA_COUNT       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STATIC_LA_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LA_VENDOR_CODE     = 3'd4;

   localparam logic [VENDOR_BITS-1:0] LA_CODE_RESET = 4'd2;
   localparam logic [VENDOR_BITS-1:0] VENDOR_NONE   = 4'd0;

   localparam logic [SOURCE_BITS-1:0] SRC_NONE         = 3'd0;
   localparam logic [SOURCE_BITS-1:0] SRC_DYN_LA       = 3'd1;
   localparam logic [SOURCE_BITS-1:0] SRC_STATIC_LA    = 3'd2;
   localparam logic [SOURCE_BITS-1:0] SRC_DYN_TABLE    = 3'd3;
   localparam logic [SOURCE_BITS-1:0] SRC_STATIC_TABLE = 3'd4;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_LOOKUP       = 3'd0,
      FUNC_WR_DYN       = 3'd1,
      FUNC_WR_STATIC    = 3'd2,
      FUNC_WR_DYN_LA    = 3'd3,
      FUNC_WR_STATIC_LA = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INIT,
      ST_CHK,
      ST_READ,
      ST_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic init;
      logic rd;
      logic step;
      logic la_mode;
      logic second;
   } ctl_cmd_type;

   typedef struct packed {
      logic lookup;
      logic la_bit;
      logic more;
      logic more_next;
      logic hit;
      logic stop;
   } ctl_status_type;

endpackage

[hdl/mac_prefix_vendor_lookup_core.sv]
`timescale 1ns / 1ps
// write or unused func: the request is captured, then DISPATCH, then RESP raises the strobe
// lookup: DISPATCH, then per table or list INIT, CHK and a READ, CMP pair per probe;
// probes up to clog2(count+1) for a sorted table (9 at 256 entries) or count for a list (16)
// one word in flight; the next start is taken in the strobe cycle, no stall on rsp
// synchronous active-high reset clears control and counts, la vendor code to 2
module mac_prefix_vendor_lookup_core #(
   parameter int TABLE_DEPTH = 256,
   parameter int LA_DEPTH    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mpvl_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [mpvl_pkg::SLOT_BITS-1:0]      req_slot,
   input  logic [mpvl_pkg::PREFIX_BITS-1:0]    req_prefix,
   input  logic [mpvl_pkg::VENDOR_BITS-1:0]    req_vendor_in,
   output logic                                rsp_valid,
   output logic [mpvl_pkg::VENDOR_BITS-1:0]    rsp_vendor,
   output logic [mpvl_pkg::SOURCE_BITS-1:0]    rsp_source,
   output logic                                rsp_locally_admin,
   input  logic                                csr_we,
   input  logic [mpvl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mpvl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mpvl_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   mpvl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mpvl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LA_DEPTH    (LA_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_func          (req_func),
      .req_slot          (req_slot),
      .req_prefix        (req_prefix),
      .req_vendor_in     (req_vendor_in),
      .cmd               (cmd),
      .status            (status),
      .rsp_vendor        (rsp_vendor),
      .rsp_source        (rsp_source),
      .rsp_locally_admin (rsp_locally_admin)
   );

endmodule

[hdl/mpvl_ctrl.sv]
`timescale 1ns / 1ps

module mpvl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  mpvl_pkg::ctl_status_type status,
   output mpvl_pkg::ctl_cmd_type    cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   import mpvl_pkg::*;

   state_type state_ff, state_in;
   logic      la_mode_ff, la_mode_in;
   logic      second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         la_mode_ff <= 1'b0;
         second_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         la_mode_ff <= la_mode_in;
         second_ff  <= second_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      la_mode_in = la_mode_ff;
      second_in  = second_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.lookup) begin
               state_in   = ST_INIT;
               la_mode_in = status.la_bit;
               second_in  = 1'b0;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_INIT: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.more) begin
               state_in = ST_READ;
            end else if (second_ff) begin
               state_in = ST_RESP;
            end else begin
               state_in  = ST_INIT;
               second_in = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.hit) begin
               state_in = ST_RESP;
            end else if (!status.stop && status.more_next) begin
               state_in = ST_READ;
            end else if (second_ff) begin
               state_in = ST_RESP;
            end else begin
               state_in  = ST_INIT;
               second_in = 1'b1;
            end
         end
         ST_RESP: begin
            state_in = start ? ST_DISPATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      cmd.clear   = 1'b0;
      cmd.init    = 1'b0;
      cmd.rd      = 1'b0;
      cmd.step    = 1'b0;
      cmd.la_mode = la_mode_ff;
      cmd.second  = second_ff;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_DISPATCH: begin
            cmd.clear = 1'b1;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
         end
         ST_READ: begin
            cmd.rd = 1'b1;
         end
         ST_CMP: begin
            cmd.step = 1'b1;
         end
         ST_RESP: begin
            busy      = 1'b0;
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
      cmd.capture = start && !busy;
   end

   ap_dispatch_after_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DISPATCH |-> $past(start))
      else $error("dispatch without a start");

   ap_read_then_cmp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_CMP)
      else $error("read not followed by compare");

   ap_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

[hdl/mpvl_datapath.sv]
`timescale 1ns / 1ps

module mpvl_datapath #(
   parameter int TABLE_DEPTH = 256,
   parameter int LA_DEPTH    = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [mpvl_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [mpvl_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic [mpvl_pkg::FUNC_BITS-1:0]           req_func,
   input  logic [mpvl_pkg::SLOT_BITS-1:0]           req_slot,
   input  logic [mpvl_pkg::PREFIX_BITS-1:0]         req_prefix,
   input  logic [mpvl_pkg::VENDOR_BITS-1:0]         req_vendor_in,
   input  mpvl_pkg::ctl_cmd_type                    cmd,
   output mpvl_pkg::ctl_status_type                 status,
   output logic [mpvl_pkg::VENDOR_BITS-1:0]         rsp_vendor,
   output logic [mpvl_pkg::SOURCE_BITS-1:0]         rsp_source,
   output logic                                     rsp_locally_admin
);
   import mpvl_pkg::*;

   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int TIW = TAW + 1;
   localparam int LAW = (LA_DEPTH > 1) ? $clog2(LA_DEPTH) : 1;
   localparam int LIW = LAW + 1;

   logic [ENTRY_BITS-1:0]  dyn_tbl_mem    [TABLE_DEPTH];
   logic [ENTRY_BITS-1:0]  static_tbl_mem [TABLE_DEPTH];
   logic [PREFIX_BITS-1:0] dyn_la_mem     [LA_DEPTH];
   logic [PREFIX_BITS-1:0] static_la_mem  [LA_DEPTH];

   logic [TBL_CNT_BITS-1:0] dyn_cnt_ff, static_cnt_ff;
   logic [LA_CNT_BITS-1:0]  dla_cnt_ff, sla_cnt_ff;
   logic [VENDOR_BITS-1:0]  la_code_ff;

   logic                   lookup_ff;
   logic [PREFIX_BITS-1:0] key_ff;
   logic [TIW-1:0]         lo_ff, hi_ff, mid_ff, mid;
   logic [LIW-1:0]         idx_ff, n_ff;
   logic [ENTRY_BITS-1:0]  dyn_rd_ff, static_rd_ff, tbl_rd;
   logic [PREFIX_BITS-1:0] dla_rd_ff, sla_rd_ff, la_rd;
   logic [VENDOR_BITS-1:0] vendor_ff;
   logic [SOURCE_BITS-1:0] source_ff;
   logic                   la_ff;

   logic                    slot_ok, la_slot_ok;
   logic [TBL_CNT_BITS-1:0] tbl_cnt;
   logic [LA_CNT_BITS-1:0]  la_cnt;
   logic [31:0]             tbl_lim, la_lim;
   logic                    tbl_eq, tbl_lt, tbl_hit, la_match;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dyn_cnt_ff    <= '0;
         static_cnt_ff <= '0;
         dla_cnt_ff    <= '0;
         sla_cnt_ff    <= '0;
         la_code_ff    <= LA_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DYN_TABLE_COUNT:    dyn_cnt_ff    <= csr_wdata[TBL_CNT_BITS-1:0];
            CSR_STATIC_TABLE_COUNT: static_cnt_ff <= csr_wdata[TBL_CNT_BITS-1:0];
            CSR_DYN_LA_COUNT:       dla_cnt_ff    <= csr_wdata[LA_CNT_BITS-1:0];
            CSR_STATIC_LA_COUNT:    sla_cnt_ff    <= csr_wdata[LA_CNT_BITS-1:0];
            CSR_LA_VENDOR_CODE:     la_code_ff    <= csr_wdata[VENDOR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // table and list writes
   assign slot_ok    = 32'(req_slot) < 32'(TABLE_DEPTH);
   assign la_slot_ok = 32'(req_slot[LA_SLOT_BITS-1:0]) < 32'(LA_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.capture && req_func == FUNC_WR_DYN && slot_ok) begin
         dyn_tbl_mem[TAW'(req_slot)] <= {req_vendor_in, req_prefix};
      end
      if (cmd.rd) begin
         dyn_rd_ff <= dyn_tbl_mem[mid[TAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_func == FUNC_WR_STATIC && slot_ok) begin
         static_tbl_mem[TAW'(req_slot)] <= {req_vendor_in, req_prefix};
      end
      if (cmd.rd) begin
         static_rd_ff <= static_tbl_mem[mid[TAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_func == FUNC_WR_DYN_LA && la_slot_ok) begin
         dyn_la_mem[LAW'(req_slot[LA_SLOT_BITS-1:0])] <= req_prefix;
      end
      if (cmd.rd) begin
         dla_rd_ff <= dyn_la_mem[idx_ff[LAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_func == FUNC_WR_STATIC_LA && la_slot_ok) begin
         static_la_mem[LAW'(req_slot[LA_SLOT_BITS-1:0])] <= req_prefix;
      end
      if (cmd.rd) begin
         sla_rd_ff <= static_la_mem[idx_ff[LAW-1:0]];
      end
   end

   // search and scan bounds
   always_comb begin
      tbl_cnt  = cmd.second ? static_cnt_ff : dyn_cnt_ff;
      la_cnt   = cmd.second ? sla_cnt_ff : dla_cnt_ff;
      tbl_lim  = (32'(tbl_cnt) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(tbl_cnt);
      la_lim   = (32'(la_cnt) > 32'(LA_DEPTH)) ? 32'(LA_DEPTH) : 32'(la_cnt);
      mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
      tbl_rd   = cmd.second ? static_rd_ff : dyn_rd_ff;
      la_rd    = cmd.second ? sla_rd_ff : dla_rd_ff;
      tbl_eq   = tbl_rd[PREFIX_BITS-1:0] == key_ff;
      tbl_lt   = tbl_rd[PREFIX_BITS-1:0] < key_ff;
      tbl_hit  = tbl_eq && (tbl_rd[ENTRY_BITS-1:PREFIX_BITS] != VENDOR_NONE);
      la_match = la_rd == key_ff;
   end

   always_comb begin
      status.lookup = lookup_ff;
      status.la_bit = key_ff[LA_BIT_POS];
      if (cmd.la_mode) begin
         status.more      = idx_ff < n_ff;
         status.more_next = (idx_ff + 1'b1) < n_ff;
         status.hit       = la_match;
         status.stop      = la_match;
      end else begin
         status.more      = lo_ff < hi_ff;
         status.more_next = tbl_lt ? ((mid_ff + 1'b1) < hi_ff) : (lo_ff < mid_ff);
         status.hit       = tbl_hit;
         status.stop      = tbl_eq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_ff <= 1'b0;
         lo_ff     <= '0;
         hi_ff     <= '0;
         mid_ff    <= '0;
         idx_ff    <= '0;
         n_ff      <= '0;
      end else begin
         if (cmd.capture) begin
            lookup_ff <= req_func == FUNC_LOOKUP;
         end
         if (cmd.init) begin
            if (cmd.la_mode) begin
               idx_ff <= '0;
               n_ff   <= LIW'(la_lim);
            end else begin
               lo_ff <= '0;
               hi_ff <= TIW'(tbl_lim);
            end
         end
         if (cmd.rd) begin
            mid_ff <= mid;
         end
         if (cmd.step) begin
            if (cmd.la_mode) begin
               idx_ff <= idx_ff + 1'b1;
            end else if (!tbl_eq) begin
               if (tbl_lt) lo_ff <= mid_ff + 1'b1;
               else hi_ff <= mid_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= req_prefix;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_ff <= VENDOR_NONE;
         source_ff <= SRC_NONE;
         la_ff     <= 1'b0;
      end else if (cmd.clear) begin
         vendor_ff <= VENDOR_NONE;
         source_ff <= SRC_NONE;
         la_ff     <= lookup_ff && key_ff[LA_BIT_POS];
      end else if (cmd.step && status.hit) begin
         if (cmd.la_mode) begin
            vendor_ff <= la_code_ff;
            source_ff <= cmd.second ? SRC_STATIC_LA : SRC_DYN_LA;
         end else begin
            vendor_ff <= tbl_rd[ENTRY_BITS-1:PREFIX_BITS];
            source_ff <= cmd.second ? SRC_STATIC_TABLE : SRC_DYN_TABLE;
         end
      end
   end

   assign rsp_vendor        = vendor_ff;
   assign rsp_source        = source_ff;
   assign rsp_locally_admin = la_ff;

   ap_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd && !cmd.la_mode |-> lo_ff < hi_ff)
      else $error("table probe outside search window");

   ap_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd && cmd.la_mode |-> idx_ff < n_ff)
      else $error("list read beyond valid count");

   ap_la_source_flag: assert property (@(posedge clock) disable iff (reset)
      source_ff == SRC_DYN_LA || source_ff == SRC_STATIC_LA |-> la_ff)
      else $error("list hit without locally administered flag");

endmodule
